### sv/sdf_pkg.sv
// Shared types and constants for the system-exclusive data-set framer.
`timescale 1ns / 1ps

package sdf_pkg;

  typedef struct packed {
    logic [31:0] address;
    logic [6:0]  data_byte;
    logic        first_of_message;
    logic        last_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
  } out_item_t;

  typedef logic [3:0] step_t;

  localparam logic [7:0] SxStart  = 8'hF0;
  localparam logic [7:0] SxEnd    = 8'hF7;
  localparam logic [7:0] SxMaker  = 8'h41;
  localparam logic [7:0] SxCmdDt1 = 8'h12;

  localparam logic [6:0]  DeviceIdReset = 7'd16;
  localparam logic [23:0] ModelIdReset  = 24'd21;

  localparam logic RegDeviceId = 1'b0;
  localparam logic RegModelId  = 1'b1;

  localparam step_t StepStart  = 4'd0;
  localparam step_t StepMaker  = 4'd1;
  localparam step_t StepDevice = 4'd2;
  localparam step_t StepModel2 = 4'd3;
  localparam step_t StepModel1 = 4'd4;
  localparam step_t StepModel0 = 4'd5;
  localparam step_t StepCmd    = 4'd6;
  localparam step_t StepAddr3  = 4'd7;
  localparam step_t StepAddr2  = 4'd8;
  localparam step_t StepAddr1  = 4'd9;
  localparam step_t StepAddr0  = 4'd10;
  localparam step_t StepData   = 4'd11;
  localparam step_t StepChk    = 4'd12;
  localparam step_t StepEnd    = 4'd13;

endpackage

### sv/sdf_front.sv
// Front end: accepts input beats, tracks the open message and drops orphans.
`timescale 1ns / 1ps

module sdf_front import sdf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output logic     q_push_o,
  input  logic     q_full_i
);

  logic in_msg_q, in_msg_d;
  logic accept;
  logic keep;

  assign full   = q_full_i;
  assign accept = push & ~q_full_i;
  assign keep   = in_item_i.first_of_message | in_msg_q;
  assign q_push_o = accept & keep;

  always_comb begin
    in_msg_d = in_msg_q;
    if (accept && keep) begin
      in_msg_d = ~in_item_i.last_of_message;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
    end else begin
      in_msg_q <= in_msg_d;
    end
  end

endmodule

### sv/sdf_fifo.sv
// Short queue of classified items between front end and byte sequencer.
`timescale 1ns / 1ps

module sdf_fifo import sdf_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output in_item_t rdata_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastPtr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt = CntW'(Depth);

  in_item_t entries_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = entries_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : AddrW'(wptr_q + 1'b1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : AddrW'(rptr_q + 1'b1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = CntW'(cnt_q + 1'b1);
      2'b01:   cnt_d = CntW'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### sv/sdf_back.sv
// Back end: expands queued items into message bytes and keeps the checksum.
`timescale 1ns / 1ps

module sdf_back import sdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [6:0]  device_id_i,
  input  logic [23:0] model_id_i,
  input  logic        head_valid_i,
  input  in_item_t    head_i,
  output logic        head_pop_o,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o
);

  logic      active_q, active_d;
  step_t     step_q, step_d;
  logic [6:0] sum_q, sum_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  step_t     start_step, end_step, cur_step;
  logic      advance, done;
  logic [7:0] cur_byte;
  logic [6:0] chk;

  assign start_step = head_i.first_of_message ? StepStart : StepData;
  assign end_step   = head_i.last_of_message ? StepEnd : StepData;
  assign cur_step   = active_q ? step_q : start_step;
  assign advance    = head_valid_i & (~out_valid_q | pop);
  assign done       = (cur_step == end_step);
  assign head_pop_o = advance & done;
  assign chk        = 7'd0 - sum_q;

  always_comb begin
    unique case (cur_step)
      StepStart:  cur_byte = SxStart;
      StepMaker:  cur_byte = SxMaker;
      StepDevice: cur_byte = {1'b0, device_id_i};
      StepModel2: cur_byte = model_id_i[23:16];
      StepModel1: cur_byte = model_id_i[15:8];
      StepModel0: cur_byte = model_id_i[7:0];
      StepCmd:    cur_byte = SxCmdDt1;
      StepAddr3:  cur_byte = head_i.address[31:24];
      StepAddr2:  cur_byte = head_i.address[23:16];
      StepAddr1:  cur_byte = head_i.address[15:8];
      StepAddr0:  cur_byte = head_i.address[7:0];
      StepData:   cur_byte = {1'b0, head_i.data_byte};
      StepChk:    cur_byte = {1'b0, chk};
      StepEnd:    cur_byte = SxEnd;
      default:    cur_byte = '0;
    endcase
  end

  always_comb begin
    active_d    = active_q;
    step_d      = step_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q & ~pop;
    if (advance) begin
      out_valid_d = 1'b1;
      active_d    = ~done;
      step_d      = step_t'(cur_step + 1'b1);
      if (cur_step == StepAddr3) begin
        sum_d = cur_byte[6:0];
      end else if (cur_step == StepAddr2 || cur_step == StepAddr1 ||
                   cur_step == StepAddr0 || cur_step == StepData) begin
        sum_d = 7'(sum_q + cur_byte[6:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= StepStart;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_byte     <= cur_byte;
      out_q.end_of_frame <= (cur_step == StepEnd);
    end
  end

  assign empty      = ~out_valid_q;
  assign out_item_o = out_q;

endmodule

### sv/sysex_dt1_framer.sv
// Top level of the system-exclusive data-set message framer.
//
// Input channel: an item is taken on a clock edge with push high and full
// low. An item with first_of_message opens a message (F0, maker, device id,
// three model id bytes, command, four address bytes); every kept item then
// sends its data byte; an item with last_of_message adds the checksum and F7.
// Items that arrive while no message is open and do not open one are dropped.
// Result channel: the oldest byte sits on out_item_o while empty is low and
// is taken on an edge with pop high.
// An item's first byte appears after the queue and the byte output register.
// Throughput: one result byte per cycle from the byte sequencer, held back
// while the single byte output register is full and pop is low.
// A queue of FifoDepth items parts the input side from the sequencer, so
// input keeps flowing while the receiver holds off pop until the queue fills.
// Reset empties the queue and output, closes any open message, clears the
// checksum and loads device id 16 and model id 21.
// Configuration: APB, device_id at 0x0, model_id at 0x4; write while idle.
`timescale 1ns / 1ps

module sysex_dt1_framer import sdf_pkg::*; #(
  parameter int FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]  device_id_q, device_id_d;
  logic [23:0] model_id_q, model_id_d;
  logic        cfg_wr;
  logic        q_push, q_full, q_valid, q_pop;
  in_item_t    q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    device_id_d = device_id_q;
    model_id_d  = model_id_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        RegDeviceId: device_id_d = pwdata[6:0];
        RegModelId:  model_id_d  = pwdata[23:0];
        default:     device_id_d = device_id_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegDeviceId: prdata = {25'd0, device_id_q};
      RegModelId:  prdata = {8'd0, model_id_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= DeviceIdReset;
      model_id_q  <= ModelIdReset;
    end else begin
      device_id_q <= device_id_d;
      model_id_q  <= model_id_d;
    end
  end

  sdf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_push_o  (q_push),
    .q_full_i  (q_full)
  );

  sdf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (in_item_i),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_head)
  );

  sdf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .device_id_i  (device_id_q),
    .model_id_i   (model_id_q),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .head_pop_o   (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

endmodule

### sv/sdf_checker.sv
// Port-level checks on the framer's result stream, bound to the top level.
`timescale 1ns / 1ps

module sdf_checker import sdf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  logic frame_start_q, frame_start_d;
  logic after_start_q, after_start_d;
  logic beat;

  assign beat = pop & ~empty;

  always_comb begin
    frame_start_d = frame_start_q;
    after_start_d = after_start_q;
    if (beat) begin
      frame_start_d = out_item_o.end_of_frame;
      after_start_d = frame_start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= 1'b1;
      after_start_q <= 1'b0;
    end else begin
      frame_start_q <= frame_start_d;
      after_start_q <= after_start_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or vanished");

  a_eof_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.end_of_frame) |-> (out_item_o.out_byte == SxEnd))
    else $error("end of frame without end byte");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_start_q) |-> (out_item_o.out_byte == SxStart))
    else $error("frame does not open with start byte");

  a_maker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && after_start_q) |-> (out_item_o.out_byte == SxMaker))
    else $error("maker id missing after start byte");

endmodule

bind sysex_dt1_framer sdf_checker u_sdf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

### tb/tb.sv
// Self-checking testbench for the system-exclusive data-set framer.
`timescale 1ns / 1ps

module tb;
  import sdf_pkg::*;

  class frame_board;
    logic [6:0]  dev_id;
    logic [23:0] model_id;
    logic [6:0]  run_sum;
    logic        msg_open;
    out_item_t   pending_bytes[$];
    int          errors;
    int          beats;
    int          closed_msgs;
    int          dropped;

    function new();
      dev_id      = DeviceIdReset;
      model_id    = ModelIdReset;
      run_sum     = '0;
      msg_open    = 1'b0;
      errors      = 0;
      beats       = 0;
      closed_msgs = 0;
      dropped     = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == RegDeviceId) begin
        dev_id = val[6:0];
      end else begin
        model_id = val[23:0];
      end
    endfunction

    function void queue_byte(logic [7:0] b, logic eof);
      out_item_t o;
      o.out_byte     = b;
      o.end_of_frame = eof;
      pending_bytes.push_back(o);
    endfunction

    function void predict_frame(in_item_t it);
      logic [7:0] b;
      if (!it.first_of_message && !msg_open) begin
        dropped++;
        return;
      end
      if (it.first_of_message) begin
        run_sum  = '0;
        msg_open = 1'b1;
        queue_byte(SxStart, 1'b0);
        queue_byte(SxMaker, 1'b0);
        queue_byte({1'b0, dev_id}, 1'b0);
        queue_byte(model_id[23:16], 1'b0);
        queue_byte(model_id[15:8], 1'b0);
        queue_byte(model_id[7:0], 1'b0);
        queue_byte(SxCmdDt1, 1'b0);
        for (int i = 3; i >= 0; i--) begin
          b = it.address[8*i +: 8];
          run_sum = run_sum + b[6:0];
          queue_byte(b, 1'b0);
        end
      end
      run_sum = run_sum + it.data_byte;
      queue_byte({1'b0, it.data_byte}, 1'b0);
      if (it.last_of_message) begin
        queue_byte({1'b0, 7'd0 - run_sum}, 1'b0);
        queue_byte(SxEnd, 1'b1);
        run_sum  = '0;
        msg_open = 1'b0;
        closed_msgs++;
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_beat(out_item_t got);
      out_item_t want;
      beats++;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected beat %02h eof %0b", got.out_byte, got.end_of_frame));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.end_of_frame !== want.end_of_frame)
        report($sformatf("end_of_frame %0b, want %0b", got.end_of_frame, want.end_of_frame));
    endtask

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        push    = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop     = 1'b0;
  out_item_t   out_item;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  int gap_pct   = 0;
  int stall_pct = 0;
  int sent_items = 0;

  frame_board sb = new();

  sysex_dt1_framer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      sb.predict_frame(in_item);
    end
    if (rst_ni && pop && !empty) begin
      sb.check_beat(out_item);
    end
  end

  function automatic in_item_t mk_item(logic [31:0] addr, logic [6:0] data,
                                       logic first, logic last);
    in_item_t it;
    it.address          = addr;
    it.data_byte        = data;
    it.first_of_message = first;
    it.last_of_message  = last;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_item(mk_item(32'hFFFF_FFFF, 7'h7F, 1'b0, 1'b0));
    send_item(mk_item(32'h0000_0000, 7'h00, 1'b0, 1'b1));
    send_item(mk_item(32'h0000_0000, 7'h00, 1'b1, 1'b1));
    send_item(mk_item(32'hFFFF_FFFF, 7'h7F, 1'b1, 1'b1));
    send_item(mk_item(32'h0102_0304, 7'h76, 1'b1, 1'b1));
    send_item(mk_item(32'h1234_5678, 7'h00, 1'b1, 1'b0));
    send_item(mk_item(32'h0000_0000, 7'h7F, 1'b0, 1'b0));
    send_item(mk_item(32'hDEAD_BEEF, 7'h55, 1'b0, 1'b0));
    send_item(mk_item(32'h0000_0000, 7'h2A, 1'b0, 1'b1));
    send_item(mk_item(32'h0000_0000, 7'h10, 1'b0, 1'b0));
    send_item(mk_item(32'hA5A5_A5A5, 7'h01, 1'b1, 1'b0));
    send_item(mk_item(32'h5A5A_5A5A, 7'h02, 1'b1, 1'b0));
    send_item(mk_item(32'h0000_0000, 7'h03, 1'b0, 1'b1));
    send_item(mk_item(32'h8080_8080, 7'h00, 1'b1, 1'b0));
    send_item(mk_item(32'h0000_0000, 7'h00, 1'b0, 1'b1));
    send_item(mk_item(32'h7F7F_7F7F, 7'h40, 1'b1, 1'b0));
    send_item(mk_item(32'h0000_0000, 7'h40, 1'b1, 1'b1));
  endtask

  task automatic run_random(input int n_items);
    int       sent;
    int       len;
    logic     gen_open;
    logic     kept;
    in_item_t it;
    sent     = 0;
    gen_open = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        it.address          = $urandom;
        it.data_byte        = 7'($urandom_range(127));
        it.first_of_message = 1'($urandom_range(1));
        it.last_of_message  = 1'($urandom_range(1));
        kept     = it.first_of_message || gen_open;
        gen_open = kept && !it.last_of_message;
        if (kept) sent++;
        send_item(it);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          it.address          = ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom;
          it.data_byte        = 7'($urandom_range(127));
          it.first_of_message = (k == 0);
          it.last_of_message  = (k == len - 1) && ($urandom_range(19) != 0);
          gen_open = !it.last_of_message;
          sent++;
          send_item(it);
        end
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int gaps[4]   = '{0, 52, 0, 31};
    int stalls[4] = '{0, 0, 52, 31};
    logic [31:0] devs[4]   = '{32'd0, 32'd127, 32'd0, 32'd0};
    logic [31:0] models[4] = '{32'd0, 32'hFF_FFFF, 32'd0, 32'd0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain();
    for (int p = 0; p < 4; p++) begin
      devs[p]   = (p >= 2) ? $urandom_range(127) : devs[p];
      models[p] = (p >= 2) ? $urandom_range(24'hFF_FFFF) : models[p];
      cfg_write(RegDeviceId, devs[p]);
      cfg_write(RegModelId, models[p]);
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      run_random(120);
      drain();
    end
    if (sb.pending() != 0) sb.report($sformatf("%0d beats never arrived", sb.pending()));
    $display("sent %0d items over 4 idle/stall phases and 5 register settings",
             sent_items);
    $display("checked %0d beats in %0d closed messages, %0d orphan items dropped",
             sb.beats, sb.closed_msgs, sb.dropped);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
